// ----- sv/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// assertion helpers, clocked on aclk and quiet while aresetn is low

`ifndef ASSERT_OFF
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (prop)) else $error(msg);
`define ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(lbl, prop, msg)
`define ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

// ----- sv/bde_pkg.sv -----
`timescale 1ns / 1ps

package bde_pkg;

    localparam int DEF_TIMER_WIDTH = 32;
    localparam int DEF_COUNT_WIDTH = 32;

    localparam int DEBOUNCE_W   = 32;
    localparam int EDGE_COUNT_W = 32;
    localparam int CFG_DATA_W   = 32;
    localparam int CFG_INDEX_W  = 2;

    localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COUNT_MODE     = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL_LEVEL  = 2'd2;

    typedef enum logic [1:0] {
        MODE_BOTH    = 2'd0,
        MODE_FALLING = 2'd1,
        MODE_RISING  = 2'd2
    } edge_sel_t;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST   = '0;
    localparam logic [1:0]            COUNT_MODE_RST = MODE_FALLING;
    localparam logic                  INIT_LEVEL_RST = 1'b1;

    typedef struct packed {
        logic [DEBOUNCE_W-1:0] debounce_ticks;
        logic [1:0]            edge_sel;
        logic                  load_init;
        logic                  init_level;
    } bde_cfg_t;

    typedef struct packed {
        logic                    steady_out;
        logic                    pressed;
        logic                    released;
        logic [EDGE_COUNT_W-1:0] edge_count;
        logic                    raw_out;
    } bde_result_t;

endpackage

// ----- sv/bde_core.sv -----
`timescale 1ns / 1ps

module bde_core #(
    parameter int TIMER_WIDTH = bde_pkg::DEF_TIMER_WIDTH,
    parameter int COUNT_WIDTH = bde_pkg::DEF_COUNT_WIDTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bde_pkg::bde_cfg_t    cfg,
    input  logic                 step,
    input  logic                 pin_level,
    input  logic                 clear_count,
    output bde_pkg::bde_result_t result
);
    import bde_pkg::*;

    logic                   flicker_reg, flicker_next;
    logic                   steady_reg, steady_next;
    logic [TIMER_WIDTH-1:0] quiet_reg, quiet_next;
    logic [COUNT_WIDTH-1:0] edge_reg, edge_next;
    logic [COUNT_WIDTH-1:0] edge_base;
    logic                   fell, rose, count_it;

    always_comb begin
        flicker_next = flicker_reg;
        quiet_next   = quiet_reg;
        if (pin_level != flicker_reg) begin
            flicker_next = pin_level;
            quiet_next   = '0;
        end else if (quiet_reg != {TIMER_WIDTH{1'b1}}) begin
            quiet_next = quiet_reg + TIMER_WIDTH'(1);
        end

        steady_next = (64'(quiet_next) >= 64'(cfg.debounce_ticks)) ? pin_level : steady_reg;
        fell = steady_reg & ~steady_next;
        rose = ~steady_reg & steady_next;

        case (cfg.edge_sel)
            MODE_BOTH:    count_it = fell | rose;
            MODE_FALLING: count_it = fell;
            MODE_RISING:  count_it = rose;
            default:      count_it = 1'b0;
        endcase

        edge_base = clear_count ? '0 : edge_reg;
        edge_next = count_it ? edge_base + COUNT_WIDTH'(1) : edge_base;

        result.steady_out = steady_next;
        result.pressed    = fell;
        result.released   = rose;
        result.edge_count = EDGE_COUNT_W'(edge_next);
        result.raw_out    = pin_level;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            flicker_reg <= INIT_LEVEL_RST;
            steady_reg  <= INIT_LEVEL_RST;
            quiet_reg   <= '0;
            edge_reg    <= '0;
        end else if (cfg.load_init) begin
            flicker_reg <= cfg.init_level;
            steady_reg  <= cfg.init_level;
            quiet_reg   <= '0;
        end else if (step) begin
            flicker_reg <= flicker_next;
            steady_reg  <= steady_next;
            quiet_reg   <= quiet_next;
            edge_reg    <= edge_next;
        end
    end

endmodule

// ----- sv/button_debounce_edge_counter.sv -----
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Button debouncer with a steady-edge counter.
// Input channel (s_): one request per tick, carrying the sampled pin level
// and a flag that clears the edge count before that tick is applied.
// Result channel (m_): one result per request with the debounced level,
// one-tick pressed/released flags, the edge count and the raw level.
// The result is registered and is valid the cycle after its request is accepted.
// Throughput: one request per clock; the state update is a compare, an
// increment and a few gates between the state registers and the result
// register.
// When the receiver stalls, the result register holds its value and a new
// request is taken only in the cycle the pending result leaves.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index
// (0 debounce_ticks, 1 edge select, 2 initial_level); writing initial_level
// also reloads the raw and steady levels and restarts the quiet counter.
// Reset (aresetn low, synchronous): debounce_ticks 0, edge select falling,
// initial_level 1, both levels high, counters zero, no result pending.
module button_debounce_edge_counter #(
    parameter int TIMER_WIDTH = bde_pkg::DEF_TIMER_WIDTH,
    parameter int COUNT_WIDTH = bde_pkg::DEF_COUNT_WIDTH
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_wr_en,
    input  logic [bde_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [bde_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_pin_level,
    input  logic                               s_clear_count,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_steady_out,
    output logic                               m_pressed,
    output logic                               m_released,
    output logic [bde_pkg::EDGE_COUNT_W-1:0]   m_edge_count,
    output logic                               m_raw_out
);
    import bde_pkg::*;

    logic [DEBOUNCE_W-1:0] debounce_reg;
    logic [1:0]            mode_reg;
    logic                  init_level_reg;
    bde_cfg_t              core_cfg;
    bde_result_t           core_result;
    bde_result_t           out_reg;
    logic                  m_valid_reg;
    logic                  accept;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            debounce_reg   <= DEBOUNCE_RST;
            mode_reg       <= COUNT_MODE_RST;
            init_level_reg <= INIT_LEVEL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_DEBOUNCE_TICKS: debounce_reg   <= cfg_wdata[DEBOUNCE_W-1:0];
                REG_COUNT_MODE:     mode_reg       <= cfg_wdata[1:0];
                REG_INITIAL_LEVEL:  init_level_reg <= cfg_wdata[0];
                default:            ;
            endcase
        end
    end

    assign core_cfg.debounce_ticks = debounce_reg;
    assign core_cfg.edge_sel       = mode_reg;
    assign core_cfg.load_init      = cfg_wr_en && (cfg_index == REG_INITIAL_LEVEL);
    assign core_cfg.init_level     = cfg_wdata[0];

    bde_core #(
        .TIMER_WIDTH(TIMER_WIDTH),
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (core_cfg),
        .step        (accept),
        .pin_level   (s_pin_level),
        .clear_count (s_clear_count),
        .result      (core_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (accept) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_reg <= core_result;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_steady_out = out_reg.steady_out;
    assign m_pressed    = out_reg.pressed;
    assign m_released   = out_reg.released;
    assign m_edge_count = out_reg.edge_count;
    assign m_raw_out    = out_reg.raw_out;

    // a request always lands in the result register
    `ASSERT_CLK(a_accept_gives_result, accept |=> m_valid, "accepted request gave no result")
    `ASSERT_CLK(a_raw_passes, accept |=> (m_raw_out == $past(s_pin_level)), "raw level lost")
    `ASSERT_NEVER(a_pulse_excl, m_valid && m_pressed && m_released, "pressed and released together")
    `ASSERT_CLK(a_pressed_low, (m_valid && m_pressed) |-> !m_steady_out, "pressed with steady high")
    `ASSERT_CLK(a_released_high, (m_valid && m_released) |-> m_steady_out, "released with steady low")

endmodule
